// ----- rtl/two_layer_perceptron_inference_assert.svh -----
// Assertion macros for the perceptron inference block.
// Used by two_layer_perceptron_inference.sv; expects clk and arst_n in scope.
`ifndef TWO_LAYER_PERCEPTRON_INFERENCE_ASSERT_SVH
`define TWO_LAYER_PERCEPTRON_INFERENCE_ASSERT_SVH

// same-cycle implication
`define TLPI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TLPI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tlpi_pkg.sv -----
// Package for the perceptron inference block: codes, sizes and activation tables.
// No dependencies; used by two_layer_perceptron_inference.sv.
`timescale 1ns / 1ps

package tlpi_pkg;

	localparam int MaxInputs  = 64;
	localparam int MaxHidden  = 32;
	localparam int MaxOutputs = 16;

	// operation codes on the input tuser
	typedef enum logic [1:0] {
		OP_HIDDEN_W = 2'd0,
		OP_OUTPUT_W = 2'd1,
		OP_FEATURE  = 2'd2
	} op_t;

	// configuration register indexes
	localparam logic [1:0] CFG_INPUT_COUNT  = 2'd0;
	localparam logic [1:0] CFG_HIDDEN_COUNT = 2'd1;
	localparam logic [1:0] CFG_OUTPUT_COUNT = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_RND,
		ST_ACT,
		ST_EMIT
	} state_t;

	typedef logic signed [13:0] tanh_tab_t [256];
	typedef logic [12:0]        sig_tab_t  [256];

	localparam logic [63:0] ExpStep = 64'd4162825044;
	localparam logic [63:0] OneQ32  = 64'h1_0000_0000;
	localparam logic [63:0] HalfQ32 = 64'h8000_0000;

	// restoring division, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic tanh_tab_t build_tanh();
		tanh_tab_t tab;
		logic [63:0] c2, t, s, num, den, th;
		c2 = (ExpStep * ExpStep + HalfQ32) >> 32;
		t  = ExpStep;
		for (int k = 0; k < 128; k++) begin
			s   = (t * t + HalfQ32) >> 32;
			num = (OneQ32 - s) * 64'd4096;
			den = OneQ32 + s;
			th  = udiv64(num + (den >> 1), den);
			tab[128 + k] = 14'(th);
			tab[127 - k] = -14'(th);
			t = (t * c2 + HalfQ32) >> 32;
		end
		return tab;
	endfunction

	function automatic sig_tab_t build_sig();
		sig_tab_t tab;
		logic [63:0] c2, t, d2;
		c2 = (ExpStep * ExpStep + HalfQ32) >> 32;
		t  = ExpStep;
		for (int k = 0; k < 128; k++) begin
			d2 = OneQ32 + t;
			tab[128 + k] = 13'(udiv64((64'd1 << 44) + (d2 >> 1), d2));
			tab[127 - k] = 13'(udiv64(64'd4096 * t + (d2 >> 1), d2));
			t = (t * c2 + HalfQ32) >> 32;
		end
		return tab;
	endfunction

	localparam tanh_tab_t TanhTab = build_tanh();
	localparam sig_tab_t  SigTab  = build_sig();

endpackage

// ----- rtl/two_layer_perceptron_inference.sv -----
// Two-layer perceptron inference (tanh hidden layer, sigmoid outputs), Q3.12.
// Depends on tlpi_pkg and two_layer_perceptron_inference_assert.svh.
`timescale 1ns / 1ps
//
// Usage:
//  Input stream (s_axis_*): each word is a hidden weight, an output weight or a
//  feature, chosen by tuser. Weights go to on-chip stores; features to a
//  buffer. A feature word with tlast set starts one forward pass.
//  Output stream (m_axis_*): one word per output unit in use, index and
//  sigmoid value; tlast marks the last output of the pass.
//  Config port: cfg_we writes cfg_data to the count register cfg_index
//  (0 inputs, 1 hidden units, 2 outputs); write only while idle.
//  Load words are accepted back to back while idle. A pass uses one shared
//  multiply-accumulate: each dot product issues its reads, drains the read and
//  multiply stages, then rounds and does the table lookup; the multiplier does
//  one product per cycle while a dot product issues.
//  The input is not ready while a pass runs. When the receiver stalls the
//  current result word holds and the pass waits.
//  Reset clears counts to 1 and the sequencer to idle; stores are not cleared.
module two_layer_perceptron_inference (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // row_index[5:0], column_index[10:6], sample_value[26:11], zero pad
	input  logic [1:0]  s_axis_tuser,  // operation[1:0]
	input  logic        s_axis_tlast,  // example_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // output_index[3:0], probability[16:4], zero pad
	output logic        m_axis_tlast,  // result_last
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import tlpi_pkg::*;

	`include "two_layer_perceptron_inference_assert.svh"

	state_t state_q, state_d;

	logic [6:0] input_count_q;
	logic [5:0] hidden_count_q;
	logic [4:0] output_count_q;
	logic [5:0] ni_m1;
	logic [4:0] nh_m1;
	logic [3:0] no_m1;

	logic       layer_q, layer_d;
	logic [5:0] k_q, k_d;
	logic [4:0] u_q, u_d;

	// input field unpack
	logic [5:0]        in_row;
	logic [4:0]        in_col;
	logic signed [15:0] in_val;
	logic              in_acc;
	assign in_row = s_axis_tdata[5:0];
	assign in_col = s_axis_tdata[10:6];
	assign in_val = s_axis_tdata[26:11];
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_count_q  <= 7'd1;
			hidden_count_q <= 6'd1;
			output_count_q <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INPUT_COUNT:  input_count_q  <= cfg_data;
				CFG_HIDDEN_COUNT: hidden_count_q <= cfg_data[5:0];
				CFG_OUTPUT_COUNT: output_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// clamped counts, minus one
	always_comb begin
		if (input_count_q == 7'd0)       ni_m1 = 6'd0;
		else if (input_count_q > 7'd64)  ni_m1 = 6'd63;
		else                             ni_m1 = 6'(input_count_q - 7'd1);
		if (hidden_count_q == 6'd0)      nh_m1 = 5'd0;
		else if (hidden_count_q > 6'd32) nh_m1 = 5'd31;
		else                             nh_m1 = 5'(hidden_count_q - 6'd1);
		if (output_count_q == 5'd0)      no_m1 = 4'd0;
		else if (output_count_q > 5'd16) no_m1 = 4'd15;
		else                             no_m1 = 4'(output_count_q - 5'd1);
	end

	// stores
	logic signed [15:0] hw_mem [MaxInputs * MaxHidden];
	logic signed [15:0] ow_mem [MaxHidden * MaxOutputs];
	logic signed [15:0] feat_mem [MaxInputs];
	logic signed [15:0] act_mem [MaxHidden];
	logic signed [15:0] hw_rd_s1, ow_rd_s1, feat_rd_s1, act_rd_s1;

	logic hw_we, ow_we, feat_we, act_we;
	logic signed [15:0] act_wd;
	assign hw_we   = in_acc && (s_axis_tuser == OP_HIDDEN_W);
	assign ow_we   = in_acc && (s_axis_tuser == OP_OUTPUT_W) && !in_row[5] && !in_col[4];
	assign feat_we = in_acc && (s_axis_tuser == OP_FEATURE);
	assign act_we  = (state_q == ST_ACT) && !layer_q;

	always_ff @(posedge clk) begin
		if (hw_we) hw_mem[{in_row, in_col}] <= in_val;
		hw_rd_s1 <= hw_mem[{k_q, u_q}];
	end

	always_ff @(posedge clk) begin
		if (ow_we) ow_mem[{in_row[4:0], in_col[3:0]}] <= in_val;
		ow_rd_s1 <= ow_mem[{k_q[4:0], u_q[3:0]}];
	end

	always_ff @(posedge clk) begin
		if (feat_we) feat_mem[in_row] <= in_val;
		feat_rd_s1 <= feat_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (act_we) act_mem[u_q] <= act_wd;
		act_rd_s1 <= act_mem[k_q[4:0]];
	end

	// shared multiply-accumulate pipeline
	logic               rd_vld_s1, rd_last_s1;
	logic               prod_vld_s2, prod_last_s2;
	logic signed [31:0] prod_s2;
	logic signed [39:0] acc_q;
	logic signed [15:0] op_a, op_b;
	logic               issue;

	assign issue = (state_q == ST_RUN);
	assign op_a  = layer_q ? act_rd_s1 : feat_rd_s1;
	assign op_b  = layer_q ? ow_rd_s1  : hw_rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			prod_vld_s2 <= 1'b0;
			prod_last_s2 <= 1'b0;
		end else begin
			rd_vld_s1    <= issue;
			rd_last_s1   <= issue && (layer_q ? (k_q == {1'b0, nh_m1}) : (k_q == ni_m1));
			prod_vld_s2  <= rd_vld_s1;
			prod_last_s2 <= rd_vld_s1 && rd_last_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (state_q == ST_RND) begin
			acc_q <= '0;
		end else if (prod_vld_s2) begin
			acc_q <= acc_q + {{8{prod_s2[31]}}, prod_s2};
		end
	end

	// round half up to Q3.12 and saturate
	logic signed [39:0] acc_rnd;
	logic signed [27:0] acc_sh;
	logic signed [15:0] z_d, z_q;
	assign acc_rnd = acc_q + 40'sd2048;
	assign acc_sh  = 28'(acc_rnd >>> 12);
	always_comb begin
		if (acc_sh > 28'sd32767)       z_d = 16'sh7FFF;
		else if (acc_sh < -28'sd32768) z_d = 16'sh8000;
		else                           z_d = acc_sh[15:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RND) z_q <= z_d;
	end

	// nearest-entry table index: (z + 32768) >> 8
	logic [7:0] tab_idx;
	assign tab_idx = {~z_q[15], z_q[14:8]};
	assign act_wd  = 16'(TanhTab[tab_idx]);

	// result register
	logic [3:0]  res_index_q;
	logic [12:0] res_prob_q;
	logic        res_last_q;
	always_ff @(posedge clk) begin
		if ((state_q == ST_ACT) && layer_q) begin
			res_index_q <= u_q[3:0];
			res_prob_q  <= SigTab[tab_idx];
			res_last_q  <= (u_q[3:0] == no_m1);
		end
	end

	assign m_axis_tvalid = (state_q == ST_EMIT);
	assign m_axis_tdata  = {7'd0, res_prob_q, res_index_q};
	assign m_axis_tlast  = res_last_q;
	assign s_axis_tready = (state_q == ST_IDLE);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			layer_q <= 1'b0;
			k_q     <= '0;
			u_q     <= '0;
		end else begin
			state_q <= state_d;
			layer_q <= layer_d;
			k_q     <= k_d;
			u_q     <= u_d;
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		layer_d = layer_q;
		k_d     = k_q;
		u_d     = u_q;
		case (state_q)
			ST_IDLE: begin
				if (feat_we && s_axis_tlast) begin
					state_d = ST_RUN;
					layer_d = 1'b0;
					k_d     = '0;
					u_d     = '0;
				end
			end
			ST_RUN: begin
				if (layer_q ? (k_q == {1'b0, nh_m1}) : (k_q == ni_m1)) begin
					state_d = ST_DRAIN;
				end else begin
					k_d = k_q + 6'd1;
				end
			end
			ST_DRAIN: begin
				if (prod_vld_s2 && prod_last_s2) state_d = ST_RND;
			end
			ST_RND: begin
				state_d = ST_ACT;
			end
			ST_ACT: begin
				k_d = '0;
				if (layer_q) begin
					state_d = ST_EMIT;
				end else if (u_q == nh_m1) begin
					state_d = ST_RUN;
					layer_d = 1'b1;
					u_d     = '0;
				end else begin
					state_d = ST_RUN;
					u_d     = u_q + 5'd1;
				end
			end
			ST_EMIT: begin
				if (m_axis_tready) begin
					if (u_q[3:0] == no_m1) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_RUN;
						u_d     = u_q + 5'd1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// checks
	`TLPI_ASSERT_NOW(a_no_accept_in_pass, m_axis_tvalid, !s_axis_tready, "input ready during pass")
	`TLPI_ASSERT_NOW(a_mac_in_dot, prod_vld_s2, (state_q == ST_RUN || state_q == ST_DRAIN), "product outside a dot product")
	`TLPI_ASSERT_NOW(a_index_in_range, m_axis_tvalid, (m_axis_tdata[3:0] <= no_m1), "output index beyond count")
	`TLPI_ASSERT_NEXT(a_idle_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready, "not idle after last word")

endmodule

// ----- tb/tb_top.sv -----
// Testbench for two_layer_perceptron_inference: self-checking, with a predictor built in.
// Depends on tlpi_pkg (operation codes, register indexes, sizes) and the block itself.
`timescale 1ns / 1ps

module tb_top;
	import tlpi_pkg::*;

	localparam int CycleLimit = 1_000_000;
	localparam int IdleGuard  = 40;
	localparam int ItemTarget = 310;

	typedef struct {
		logic [3:0]  unit;
		logic [12:0] prob;
		logic        last;
	} score_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [6:0]  cfg_data = '0;

	two_layer_perceptron_inference dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	int           tanh_lut [256];
	int           sig_lut  [256];
	int           hid_w    [MaxInputs][MaxHidden];
	int           out_w    [MaxHidden][MaxOutputs];
	int           feat     [MaxInputs];
	int           hid_act  [MaxHidden];
	bit           hid_w_ok [MaxInputs][MaxHidden];
	bit           out_w_ok [MaxHidden][MaxOutputs];
	bit           feat_ok  [MaxInputs];
	logic [6:0]   raw_inputs = 7'd1;
	logic [5:0]   raw_hidden = 6'd1;
	logic [4:0]   raw_outputs = 5'd1;
	score_t       pending_scores [$];

	int  fails = 0;
	int  words_sent = 0;
	int  examples_run = 0;
	int  scores_seen = 0;
	int  cycles = 0;
	bit  no_idle = 1'b0;
	bit  hold_req = 1'b0;

	// activation tables, rebuilt from the exp recurrence
	function automatic void build_luts();
		longint unsigned c2, t, s, num, den, d2;
		c2 = (64'd4162825044 * 64'd4162825044 + 64'h8000_0000) >> 32;
		t  = 64'd4162825044;
		for (int k = 0; k < 128; k++) begin
			s   = (t * t + 64'h8000_0000) >> 32;
			num = (64'h1_0000_0000 - s) * 64'd4096;
			den = 64'h1_0000_0000 + s;
			tanh_lut[128 + k] = int'((num + den / 2) / den);
			tanh_lut[127 - k] = -tanh_lut[128 + k];
			d2 = 64'h1_0000_0000 + t;
			sig_lut[128 + k] = int'(((64'd1 << 44) + d2 / 2) / d2);
			sig_lut[127 - k] = int'((64'd4096 * t + d2 / 2) / d2);
			t = (t * c2 + 64'h8000_0000) >> 32;
		end
	endfunction

	function automatic int clamp_count(int v, int hi);
		return (v < 1) ? 1 : ((v > hi) ? hi : v);
	endfunction

	// round half up to Q3.12, saturate, then pick the nearest table entry
	function automatic int lut_slot(longint acc);
		longint q;
		q = (acc + 2048) >>> 12;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return int'((q + 32768) >> 8);
	endfunction

	function automatic void forward_pass();
		int ni, nh, no;
		longint acc;
		score_t sc;
		ni = clamp_count(raw_inputs, MaxInputs);
		nh = clamp_count(raw_hidden, MaxHidden);
		no = clamp_count(raw_outputs, MaxOutputs);
		for (int h = 0; h < nh; h++) begin
			acc = 0;
			for (int k = 0; k < ni; k++) acc += longint'(feat[k]) * hid_w[k][h];
			hid_act[h] = tanh_lut[lut_slot(acc)];
		end
		for (int o = 0; o < no; o++) begin
			acc = 0;
			for (int h = 0; h < nh; h++) acc += longint'(hid_act[h]) * out_w[h][o];
			sc.unit = 4'(o);
			sc.prob = 13'(sig_lut[lut_slot(acc)]);
			sc.last = (o + 1 == no);
			pending_scores.push_back(sc);
		end
		examples_run++;
	endfunction

	// update the predictor for one accepted word
	function automatic void absorb_word(op_t op, int row, int col, logic [15:0] val, bit last);
		int v;
		v = int'($signed(val));
		case (op)
			OP_HIDDEN_W: begin
				hid_w[row][col] = v;
				hid_w_ok[row][col] = 1'b1;
			end
			OP_OUTPUT_W: begin
				if (row < MaxHidden && col < MaxOutputs) begin
					out_w[row][col] = v;
					out_w_ok[row][col] = 1'b1;
				end
			end
			OP_FEATURE: begin
				feat[row] = v;
				feat_ok[row] = 1'b1;
				if (last) forward_pass();
			end
			default: ;
		endcase
	endfunction

	// one input word, with a random gap in front
	task automatic send_word(logic [1:0] op, logic [5:0] row, logic [4:0] col,
			logic [15:0] val, bit last);
		int gap;
		gap = no_idle ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14));
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, val, col, row};
		s_axis_tuser  <= op;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		absorb_word(op_t'(op), row, col, val, last);
		words_sent++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (IdleGuard) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [6:0] val);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_INPUT_COUNT:  raw_inputs  = val;
			CFG_HIDDEN_COUNT: raw_hidden  = 6'(val);
			CFG_OUTPUT_COUNT: raw_outputs = 5'(val);
			default: ;
		endcase
	endtask

	task automatic set_counts(logic [6:0] ni, logic [6:0] nh, logic [6:0] no);
		write_reg(CFG_INPUT_COUNT, ni);
		write_reg(CFG_HIDDEN_COUNT, nh);
		write_reg(CFG_OUTPUT_COUNT, no);
	endtask

	function automatic logic [15:0] rand_value();
		case ($urandom_range(0, 3))
			0: return 16'($urandom());
			1: return 16'($signed($urandom_range(0, 8191)) - 4096);
			default: return 16'($signed($urandom_range(0, 2047)) - 1024);
		endcase
	endfunction

	// fill in every weight the current counts will read
	task automatic load_missing_weights();
		int ni, nh, no;
		ni = clamp_count(raw_inputs, MaxInputs);
		nh = clamp_count(raw_hidden, MaxHidden);
		no = clamp_count(raw_outputs, MaxOutputs);
		for (int k = 0; k < ni; k++)
			for (int h = 0; h < nh; h++)
				if (!hid_w_ok[k][h]) send_word(OP_HIDDEN_W, 6'(k), 5'(h), rand_value(), 1'b0);
		for (int h = 0; h < nh; h++)
			for (int o = 0; o < no; o++)
				if (!out_w_ok[h][o]) send_word(OP_OUTPUT_W, 6'(h), 5'(o), rand_value(), 1'b0);
	endtask

	// features of one example in random order; unwritten ones always sent
	task automatic run_example();
		int ni, mark_row;
		int rows [$];
		ni = clamp_count(raw_inputs, MaxInputs);
		load_missing_weights();
		for (int k = 0; k < ni; k++)
			if (!feat_ok[k] || $urandom_range(0, 3) != 0) rows.push_back(k);
		if ($urandom_range(0, 5) == 0) rows.push_back($urandom_range(0, MaxInputs - 1));
		rows.shuffle();
		mark_row = (rows.size() == 0) ? $urandom_range(0, MaxInputs - 1) : rows.pop_back();
		foreach (rows[i]) begin
			if ($urandom_range(0, 7) == 0)
				send_word(OP_HIDDEN_W, 6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)),
					rand_value(), 1'b0);
			send_word(OP_FEATURE, 6'(rows[i]), 5'($urandom_range(0, 31)), rand_value(), 1'b0);
		end
		send_word(OP_FEATURE, 6'(mark_row), 5'($urandom_range(0, 31)), rand_value(), 1'b1);
	endtask

	task automatic test_reset_counts();
		send_word(OP_HIDDEN_W, 6'd0, 5'd0, 16'h1000, 1'b0);
		send_word(OP_OUTPUT_W, 6'd0, 5'd0, 16'h2000, 1'b0);
		send_word(OP_FEATURE, 6'd0, 5'd0, 16'h0800, 1'b1);
	endtask

	// full-scale values drive the hidden sums and one output sum into saturation both ways
	task automatic test_saturation();
		set_counts(7'd2, 7'd2, 7'd2);
		send_word(OP_HIDDEN_W, 6'd0, 5'd0, 16'h7FFF, 1'b0);
		send_word(OP_HIDDEN_W, 6'd1, 5'd0, 16'h7FFF, 1'b0);
		send_word(OP_HIDDEN_W, 6'd0, 5'd1, 16'h8000, 1'b0);
		send_word(OP_HIDDEN_W, 6'd1, 5'd1, 16'h8000, 1'b0);
		send_word(OP_OUTPUT_W, 6'd0, 5'd0, 16'h7FFF, 1'b0);
		send_word(OP_OUTPUT_W, 6'd1, 5'd0, 16'h7FFF, 1'b0);
		send_word(OP_OUTPUT_W, 6'd0, 5'd1, 16'h8000, 1'b0);
		send_word(OP_OUTPUT_W, 6'd1, 5'd1, 16'h7FFF, 1'b0);
		send_word(OP_FEATURE, 6'd0, 5'd0, 16'h7FFF, 1'b0);
		send_word(OP_FEATURE, 6'd1, 5'd31, 16'h7FFF, 1'b1);
		send_word(OP_FEATURE, 6'd0, 5'd0, 16'h8000, 1'b0);
		send_word(OP_FEATURE, 6'd1, 5'd0, 16'h8000, 1'b1);
		send_word(OP_FEATURE, 6'd1, 5'd0, 16'h0000, 1'b1);
	endtask

	// operation three and out-of-range output weights change nothing; marked weights start no pass
	task automatic test_ignored_words();
		send_word(2'd3, 6'd0, 5'd0, 16'h1234, 1'b1);
		send_word(2'd3, 6'd63, 5'd31, 16'hFFFF, 1'b0);
		send_word(OP_HIDDEN_W, 6'd63, 5'd31, 16'h4000, 1'b1);
		send_word(OP_OUTPUT_W, 6'd1, 5'd1, 16'h0400, 1'b1);
		send_word(OP_OUTPUT_W, 6'd40, 5'd3, 16'h7FFF, 1'b0);
		send_word(OP_OUTPUT_W, 6'd2, 5'd20, 16'h7FFF, 1'b0);
		send_word(OP_FEATURE, 6'd63, 5'd0, 16'h0100, 1'b1);
	endtask

	// zero clamps up to one, all ones clamps down to the maximum, one count at a time
	task automatic test_count_extremes();
		set_counts(7'd0, 7'd0, 7'd0);
		run_example();
		set_counts(7'd127, 7'd0, 7'd0);
		run_example();
		set_counts(7'd0, 7'd63, 7'd0);
		run_example();
		set_counts(7'd0, 7'd0, 7'd31);
		run_example();
	endtask

	// random counts and stray words until the word budget is spent
	task automatic test_random_traffic();
		do begin
			if ($urandom_range(0, 5) == 0) begin
				set_counts(7'($urandom_range(1, 8)), 7'($urandom_range(1, 6)),
					7'($urandom_range(1, 16)));
				no_idle = $urandom_range(0, 3) == 0;
			end
			if ($urandom_range(0, 6) == 0) begin
				send_word(2'($urandom_range(0, 3)), 6'($urandom()), 5'($urandom()),
					16'($urandom()), 1'($urandom()) & 1'b0);
			end
			run_example();
		end while (words_sent < ItemTarget);
		no_idle = 1'b0;
	endtask

	// receiver holds off while the sender keeps offering words
	task automatic test_backpressure();
		set_counts(7'd3, 7'd2, 7'd16);
		load_missing_weights();
		wait_idle();
		hold_req = 1'b1;
		repeat (4) run_example();
	endtask

	// receiver: random stalls, and one long hold-off on request
	initial begin
		int gap;
		forever begin
			if (hold_req) begin
				gap = 400;
				hold_req = 1'b0;
			end else begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		score_t sc;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			scores_seen++;
			if (pending_scores.size() == 0) begin
				$display("%0t: unexpected word idx=%0d prob=%0d last=%0b", $time,
					m_axis_tdata[3:0], m_axis_tdata[16:4], m_axis_tlast);
				fails++;
			end else begin
				sc = pending_scores.pop_front();
				if (m_axis_tdata[3:0] !== sc.unit) begin
					$display("%0t: output_index expected %0d actual %0d", $time,
						sc.unit, m_axis_tdata[3:0]);
					fails++;
				end
				if (m_axis_tdata[16:4] !== sc.prob) begin
					$display("%0t: probability expected %0d actual %0d", $time,
						sc.prob, m_axis_tdata[16:4]);
					fails++;
				end
				if (m_axis_tlast !== sc.last) begin
					$display("%0t: result_last expected %0b actual %0b", $time,
						sc.last, m_axis_tlast);
					fails++;
				end
				if (m_axis_tdata[23:17] !== 7'd0) begin
					$display("%0t: pad bits expected 0 actual %0h", $time, m_axis_tdata[23:17]);
					fails++;
				end
			end
		end
	end

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("%0t: timeout, %0d words still expected", $time, pending_scores.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		build_luts();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_counts();
		test_saturation();
		test_ignored_words();
		test_count_extremes();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		if (pending_scores.size() != 0) fails++;
		$display("Covered %0d input words, %0d forward passes, %0d result words checked,",
			words_sent, examples_run, scores_seen);
		$display("count extremes, saturation, ignored words and a long receiver stall.");
		if (fails == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
